@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks, sampled on clk and held off
// while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ECAS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define ECAS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/ecas_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Engine cycle angle scheduler package
// Word types, constants, angle helpers and the sequencer control store.
// ---------------------------------------------------------------------------
package ecas_pkg;

	localparam int NUM_CYL   = 4;
	localparam int NUM_SLOTS = (NUM_CYL > 4) ? 4 : NUM_CYL;
	localparam int SLOT_W    = 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	localparam logic [15:0] PW_MAX      = 16'd65000;
	localparam logic [12:0] ANG_X10     = 13'd7200;
	localparam logic [9:0]  ANG_DEG     = 10'd720;
	localparam logic [9:0]  HALF_DEG    = 10'd360;
	localparam logic [6:0]  TEETH_REV   = 7'd60;
	localparam logic [6:0]  WHEEL_POS_N = 7'd120;

	localparam int INJ_LEAD_TEETH = 14;
	localparam int IGN_LEAD_TEETH = 4;
	localparam logic [9:0] INJ_OFF = 10'(INJ_LEAD_TEETH * 360 / 60);
	localparam logic [9:0] IGN_OFF = 10'(IGN_LEAD_TEETH * 360 / 60);

	// five turns of 7200 lift any 16-bit advance to a positive value
	localparam logic [16:0] ADV_BIAS    = 17'd36000;
	localparam logic [12:0] DIV10_RECIP = 13'd6554;
	localparam logic [7:0]  DIV6_RECIP  = 8'd171;

	localparam logic [15:0]        HELD_PULSE_RST = 16'd1000;
	localparam logic [15:0]        HELD_DEAD_RST  = 16'd100;
	localparam logic [12:0]        HELD_SOI_RST   = 13'd100;
	localparam logic signed [15:0] HELD_ADV_RST   = 16'sd100;
	localparam logic [12:0]        HELD_DWELL_RST = 13'd1000;

	localparam logic [7:0] FIRING_SLOTS_RST = 8'd120;
	localparam logic [9:0] TDC0_RST = 10'd0;
	localparam logic [9:0] TDC1_RST = 10'd540;
	localparam logic [9:0] TDC2_RST = 10'd180;
	localparam logic [9:0] TDC3_RST = 10'd360;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIRING_SLOTS = 3'd0,
		REG_TDC0         = 3'd1,
		REG_TDC1         = 3'd2,
		REG_TDC2         = 3'd3,
		REG_TDC3         = 3'd4
	} reg_idx_t;

	typedef enum logic {
		OP_APPLY  = 1'b0,
		OP_REPLAY = 1'b1
	} upd_op_t;

	typedef logic [3:0][9:0] tdc_arr_t;

	typedef struct packed {
		upd_op_t            op;
		logic [31:0]        pulse_request;
		logic [15:0]        dead_time;
		logic [12:0]        soi_offset;
		logic signed [15:0] spark_advance;
		logic [12:0]        dwell_angle_in;
	} upd_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [1:0]        cylinder;
		logic [15:0]       pulse_ticks;
		logic [15:0]       dead_time_out;
		logic [12:0]       soi_angle;
		logic [12:0]       spark_angle;
		logic [12:0]       dwell_start_angle;
		logic [6:0]        inj_trigger_pos;
		logic [6:0]        coil_set_pos;
		logic [6:0]        coil_clear_pos;
		logic              was_clamped;
		logic              last;
	} res_t;

	// datapath operations
	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_PREP,
		DP_RED,
		DP_SLOT_A,
		DP_SLOT_B,
		DP_SLOT_C,
		DP_SLOT_D,
		DP_EMIT
	} dp_op_t;

	// sequencer branch kinds
	typedef enum logic [1:0] {
		BR_NEXT,
		BR_WAIT_IN,
		BR_EMIT,
		BR_JUMP
	} br_t;

	typedef logic [3:0] step_t;

	localparam step_t STEP_IDLE = 4'd0;
	localparam step_t STEP_SLOT = 4'd6;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] red_shift;
		br_t        br;
		step_t      target;
	} ctrl_t;

	typedef struct packed {
		logic out_busy;
		logic last_slot;
	} stat_t;

	// control store: one word per step
	function automatic ctrl_t ucode(input step_t s);
		ctrl_t w;
		w = '{op: DP_NOP, red_shift: 2'd0, br: BR_JUMP, target: STEP_IDLE};
		case (s)
			4'd0:  w = '{op: DP_LOAD,   red_shift: 2'd0, br: BR_WAIT_IN, target: STEP_IDLE};
			4'd1:  w = '{op: DP_PREP,   red_shift: 2'd0, br: BR_NEXT,    target: STEP_IDLE};
			4'd2:  w = '{op: DP_RED,    red_shift: 2'd3, br: BR_NEXT,    target: STEP_IDLE};
			4'd3:  w = '{op: DP_RED,    red_shift: 2'd2, br: BR_NEXT,    target: STEP_IDLE};
			4'd4:  w = '{op: DP_RED,    red_shift: 2'd1, br: BR_NEXT,    target: STEP_IDLE};
			4'd5:  w = '{op: DP_RED,    red_shift: 2'd0, br: BR_NEXT,    target: STEP_IDLE};
			4'd6:  w = '{op: DP_SLOT_A, red_shift: 2'd0, br: BR_NEXT,    target: STEP_IDLE};
			4'd7:  w = '{op: DP_SLOT_B, red_shift: 2'd0, br: BR_NEXT,    target: STEP_IDLE};
			4'd8:  w = '{op: DP_SLOT_C, red_shift: 2'd0, br: BR_NEXT,    target: STEP_IDLE};
			4'd9:  w = '{op: DP_SLOT_D, red_shift: 2'd0, br: BR_NEXT,    target: STEP_IDLE};
			4'd10: w = '{op: DP_EMIT,   red_shift: 2'd0, br: BR_EMIT,    target: STEP_SLOT};
			default: w = '{op: DP_NOP,  red_shift: 2'd0, br: BR_JUMP,    target: STEP_IDLE};
		endcase
		return w;
	endfunction

	function automatic logic [9:0] mod720(input logic [9:0] x);
		return (x >= ANG_DEG) ? 10'(x - ANG_DEG) : x;
	endfunction

	function automatic logic [12:0] mod7200(input logic [12:0] x);
		return (x >= ANG_X10) ? 13'(x - ANG_X10) : x;
	endfunction

	// (a - b) mod 7200 for a, b already below 7200
	function automatic logic [12:0] angle_sub(input logic [12:0] a, input logic [12:0] b);
		logic [13:0] t;
		t = {1'b0, a} + {1'b0, ANG_X10} - {1'b0, b};
		return (t >= {1'b0, ANG_X10}) ? 13'(t - {1'b0, ANG_X10}) : t[12:0];
	endfunction

	// x / 10 for x below 7200, by reciprocal
	function automatic logic [9:0] div10(input logic [12:0] x);
		logic [25:0] p;
		p = {13'b0, x} * {13'b0, DIV10_RECIP};
		return p[25:16];
	endfunction

	function automatic logic [9:0] back_deg(input logic [9:0] deg, input logic [9:0] off);
		return (deg >= off) ? 10'(deg - off) : 10'(deg + ANG_DEG - off);
	endfunction

	// whole degrees to phase*60 + tooth, six degrees per tooth
	function automatic logic [6:0] wheel_pos(input logic [9:0] deg);
		logic        ph;
		logic [8:0]  r;
		logic [16:0] p;
		logic [6:0]  tooth;
		ph    = (deg >= HALF_DEG);
		r     = ph ? 9'(deg - HALF_DEG) : deg[8:0];
		p     = {8'b0, r} * {9'b0, DIV6_RECIP};
		tooth = p[16:10];
		return ph ? 7'(tooth + TEETH_REV) : tooth;
	endfunction

endpackage

@@ design/ecas_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Scheduler channels
// Valid/ready channels for update words in and slot result words out.
// ---------------------------------------------------------------------------
interface ecas_upd_if;
	import ecas_pkg::*;
	logic valid;
	logic ready;
	upd_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ecas_res_if;
	import ecas_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ design/ecas_seq.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Scheduler sequencer
// Step counter over the control store, with waits and conditional jumps.
// ---------------------------------------------------------------------------
module ecas_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            upd_fire,
	input  ecas_pkg::stat_t stat,
	output ecas_pkg::ctrl_t ctrl
);
	import ecas_pkg::*;

	step_t step_q;
	step_t step_nxt;

	assign ctrl = ucode(step_q);

	always_comb begin
		case (ctrl.br)
			BR_NEXT:    step_nxt = 4'(step_q + 4'd1);
			BR_WAIT_IN: step_nxt = upd_fire ? 4'(step_q + 4'd1) : step_q;
			BR_EMIT: begin
				// hold while the result register is still full
				if (stat.out_busy)
					step_nxt = step_q;
				else if (stat.last_slot)
					step_nxt = STEP_IDLE;
				else
					step_nxt = ctrl.target;
			end
			BR_JUMP:    step_nxt = ctrl.target;
			default:    step_nxt = STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_nxt;
		end
	end

endmodule

@@ design/ecas_dp.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Scheduler datapath
// Held update values, advance reduction, per-slot angle and trigger math
// and the result register.
// ---------------------------------------------------------------------------
module ecas_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  ecas_pkg::ctrl_t    ctrl,
	input  logic               upd_fire,
	input  ecas_pkg::upd_t     upd_data,
	input  logic [7:0]         firing_slots,
	input  ecas_pkg::tdc_arr_t tdc_cfg,
	output ecas_pkg::stat_t    stat,
	output logic               res_valid,
	input  logic               res_ready,
	output ecas_pkg::res_t     res_data
);
	import ecas_pkg::*;

	// held update values
	logic [15:0]        held_pulse_q;
	logic [15:0]        held_dead_q;
	logic [12:0]        held_soi_q;
	logic signed [15:0] held_adv_q;
	logic [12:0]        held_dwell_q;
	logic [31:0]        clamp_count_q;
	logic               clamped_q;

	logic [SLOT_W-1:0]  slot_q;
	logic               res_valid_q;
	res_t               res_q;

	// work registers
	logic [12:0] soi_m_q;
	logic [12:0] dwell_m_q;
	logic [16:0] acc_q;
	logic [1:0]  cyl_q;
	logic [9:0]  tdc_deg_q;
	logic [12:0] soi_q;
	logic [12:0] spark_q;
	logic [9:0]  inj_deg_q;
	logic [12:0] dws_q;
	logic [9:0]  spark_deg_q;
	logic [6:0]  inj_pos_q;
	logic [9:0]  dws_deg_q;
	logic [6:0]  clear_pos_q;

	logic        out_busy;
	logic        emit;
	logic [1:0]  cyl_sel;
	logic [16:0] red_sub;
	logic [12:0] tdc_x10;

	assign out_busy       = res_valid_q && !res_ready;
	assign emit           = (ctrl.op == DP_EMIT) && !out_busy;
	assign stat.out_busy  = out_busy;
	assign stat.last_slot = (slot_q == SLOT_W'(NUM_SLOTS - 1));

	assign cyl_sel = firing_slots[{slot_q, 1'b0} +: 2];
	assign red_sub = {4'b0, ANG_X10} << ctrl.red_shift;
	assign tdc_x10 = ({3'b0, tdc_deg_q} << 3) + ({3'b0, tdc_deg_q} << 1);

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_pulse_q  <= HELD_PULSE_RST;
			held_dead_q   <= HELD_DEAD_RST;
			held_soi_q    <= HELD_SOI_RST;
			held_adv_q    <= HELD_ADV_RST;
			held_dwell_q  <= HELD_DWELL_RST;
			clamp_count_q <= '0;
			clamped_q     <= 1'b0;
			slot_q        <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			if ((ctrl.op == DP_LOAD) && upd_fire) begin
				if (upd_data.op == OP_APPLY) begin
					if (upd_data.pulse_request > {16'b0, PW_MAX}) begin
						held_pulse_q  <= PW_MAX;
						clamped_q     <= 1'b1;
						clamp_count_q <= clamp_count_q + 32'd1;
					end else begin
						held_pulse_q <= upd_data.pulse_request[15:0];
						clamped_q    <= 1'b0;
					end
					held_dead_q  <= upd_data.dead_time;
					held_soi_q   <= upd_data.soi_offset;
					held_adv_q   <= upd_data.spark_advance;
					held_dwell_q <= upd_data.dwell_angle_in;
				end else begin
					clamped_q <= 1'b0;
				end
			end
			if (ctrl.op == DP_PREP)
				slot_q <= '0;
			else if (emit)
				slot_q <= SLOT_W'(slot_q + 1'b1);
			if (emit)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			DP_PREP: begin
				soi_m_q   <= mod7200(held_soi_q);
				dwell_m_q <= mod7200(held_dwell_q);
				acc_q     <= {held_adv_q[15], held_adv_q} + ADV_BIAS;
			end
			DP_RED: begin
				// binary reduction of the biased advance modulo 7200
				if (acc_q >= red_sub)
					acc_q <= acc_q - red_sub;
			end
			DP_SLOT_A: begin
				cyl_q     <= cyl_sel;
				tdc_deg_q <= mod720(tdc_cfg[cyl_sel]);
			end
			DP_SLOT_B: begin
				soi_q     <= angle_sub(tdc_x10, soi_m_q);
				spark_q   <= angle_sub(tdc_x10, acc_q[12:0]);
				inj_deg_q <= back_deg(tdc_deg_q, INJ_OFF);
			end
			DP_SLOT_C: begin
				dws_q       <= angle_sub(spark_q, dwell_m_q);
				spark_deg_q <= div10(spark_q);
				inj_pos_q   <= wheel_pos(inj_deg_q);
			end
			DP_SLOT_D: begin
				dws_deg_q   <= div10(dws_q);
				clear_pos_q <= wheel_pos(back_deg(spark_deg_q, IGN_OFF));
			end
			DP_EMIT: begin
				if (!out_busy) begin
					res_q.slot              <= slot_q;
					res_q.cylinder          <= cyl_q;
					res_q.pulse_ticks       <= held_pulse_q;
					res_q.dead_time_out     <= held_dead_q;
					res_q.soi_angle         <= soi_q;
					res_q.spark_angle       <= spark_q;
					res_q.dwell_start_angle <= dws_q;
					res_q.inj_trigger_pos   <= inj_pos_q;
					res_q.coil_set_pos      <= wheel_pos(back_deg(dws_deg_q, IGN_OFF));
					res_q.coil_clear_pos    <= clear_pos_q;
					res_q.was_clamped       <= clamped_q;
					res_q.last              <= stat.last_slot;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ design/engine_cycle_angle_scheduler_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Engine cycle angle scheduler
// Takes an update word and returns one schedule word per firing slot.
// ---------------------------------------------------------------------------
//  channel  dir  handshake      word
//  upd      in   valid/ready    update: op, pulse, dead time, SOI, advance, dwell
//  res      out  valid/ready    slot schedule, one per slot, last flags slot 3
//  wr_*     in   wr_en only     register write, index 0 slots, 1..4 TDC offsets
//
// An update runs from accept to the next accept as one accept step,
// one setup step, four compare-subtract steps reducing the spark advance
// modulo 7200, then five control-store steps per slot.
// upd.ready is high only in the idle step; a stalled res holds the emit step.
// arst_n restores register defaults and held values and empties res.
// ---------------------------------------------------------------------------
module engine_cycle_angle_scheduler_core (
	input  logic                               clk,
	input  logic                               arst_n,
	ecas_upd_if.sink                           upd,
	ecas_res_if.source                         res,
	input  logic                               wr_en,
	input  logic [ecas_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [ecas_pkg::CFG_DATA_W-1:0]    wr_data
);
	import ecas_pkg::*;

	logic [7:0] firing_slots_q;
	tdc_arr_t   tdc_q;
	ctrl_t      ctrl;
	stat_t      stat;
	logic       upd_fire;

	assign upd.ready = (ctrl.br == BR_WAIT_IN);
	assign upd_fire  = upd.valid && upd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			firing_slots_q <= FIRING_SLOTS_RST;
			tdc_q[0]       <= TDC0_RST;
			tdc_q[1]       <= TDC1_RST;
			tdc_q[2]       <= TDC2_RST;
			tdc_q[3]       <= TDC3_RST;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_FIRING_SLOTS: firing_slots_q <= wr_data[7:0];
				REG_TDC0:         tdc_q[0] <= wr_data;
				REG_TDC1:         tdc_q[1] <= wr_data;
				REG_TDC2:         tdc_q[2] <= wr_data;
				REG_TDC3:         tdc_q[3] <= wr_data;
				default: ;
			endcase
		end
	end

	ecas_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd_fire (upd_fire),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	ecas_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.upd_fire     (upd_fire),
		.upd_data     (upd.data),
		.firing_slots (firing_slots_q),
		.tdc_cfg      (tdc_q),
		.stat         (stat),
		.res_valid    (res.valid),
		.res_ready    (res.ready),
		.res_data     (res.data)
	);

endmodule

@@ design/ecas_chk.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Scheduler port checker
// Watches the top-level channels for ordering and range slips.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ecas_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           upd_valid,
	input logic           upd_ready,
	input logic           res_valid,
	input logic           res_ready,
	input ecas_pkg::res_t res_data
);
	import ecas_pkg::*;

	logic upd_seen;
	assign upd_seen = upd_valid || !upd_valid;

	`ECAS_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data), "result word changed while stalled")
	`ECAS_ASSERT_IMP(a_angle_range, res_valid, (res_data.soi_angle < ANG_X10) && (res_data.spark_angle < ANG_X10) && (res_data.dwell_start_angle < ANG_X10), "angle out of range")
	`ECAS_ASSERT_IMP(a_pos_range, res_valid, (res_data.inj_trigger_pos < WHEEL_POS_N) && (res_data.coil_set_pos < WHEEL_POS_N) && (res_data.coil_clear_pos < WHEEL_POS_N) && (res_data.pulse_ticks <= PW_MAX), "trigger position or pulse out of range")
	`ECAS_ASSERT_IMP(a_busy_no_accept, upd_seen && res_valid && !res_data.last, !upd_ready, "update taken while slots pending")
	`ECAS_ASSERT_IMP(a_last_clamp, res_valid, (res_data.last == (res_data.slot == SLOT_W'(NUM_SLOTS - 1))) && (!res_data.was_clamped || (res_data.pulse_ticks == PW_MAX)), "last flag or clamp flag inconsistent")

endmodule

bind engine_cycle_angle_scheduler_core ecas_chk u_ecas_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.upd_valid (upd.valid),
	.upd_ready (upd.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);

@@ tb/sv/tb_engine_cycle_angle_scheduler_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Engine cycle angle scheduler testbench
// Drives update words and register writes into the scheduler core, predicts
// the four slot schedule words of every accepted update and compares each
// returned word field by field. It covers directed corner values first, then
// random phases with random register settings, random idling on both
// channels, a long output stall and drains between phases.
// ---------------------------------------------------------------------------
module tb_engine_cycle_angle_scheduler_core;
	import ecas_pkg::*;

	localparam int TURN_X10      = 7200;
	localparam int TURN_DEG      = 720;
	localparam int HALF_TURN     = 360;
	localparam int TEETH         = 60;
	localparam int DEG_PER_TOOTH = HALF_TURN / TEETH;
	localparam int INJ_BACK      = INJ_LEAD_TEETH * DEG_PER_TOOTH;
	localparam int IGN_BACK      = IGN_LEAD_TEETH * DEG_PER_TOOTH;
	localparam int PULSE_LIMIT   = 65000;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 40;

	class slot_schedule_board;
		logic [7:0]        firing_slots;
		logic [9:0]        tdc_deg_reg[4];
		logic [15:0]       held_pulse;
		logic [15:0]       held_dead;
		logic [12:0]       held_soi;
		logic signed [15:0] held_adv;
		logic [12:0]       held_dwell;
		int unsigned       clamp_total;
		int unsigned       failures;
		res_t              expected_slots[$];

		function new();
			firing_slots   = 8'd120;
			tdc_deg_reg[0] = 10'd0;
			tdc_deg_reg[1] = 10'd540;
			tdc_deg_reg[2] = 10'd180;
			tdc_deg_reg[3] = 10'd360;
			held_pulse     = 16'd1000;
			held_dead      = 16'd100;
			held_soi       = 13'd100;
			held_adv       = 16'sd100;
			held_dwell     = 13'd1000;
			clamp_total    = 0;
			failures       = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [9:0] v);
			case (idx)
				REG_FIRING_SLOTS: firing_slots = v[7:0];
				REG_TDC0: tdc_deg_reg[0] = v;
				REG_TDC1: tdc_deg_reg[1] = v;
				REG_TDC2: tdc_deg_reg[2] = v;
				REG_TDC3: tdc_deg_reg[3] = v;
				default: ;
			endcase
		endfunction

		function int step_back(int deg, int off);
			return (deg >= off) ? deg - off : deg + TURN_DEG - off;
		endfunction

		// phase*60 + tooth, six degrees per tooth position
		function logic [6:0] wheel_code(int deg);
			return 7'((deg >= HALF_TURN ? TEETH : 0) + (deg % HALF_TURN) * TEETH / HALF_TURN);
		endfunction

		function void note_update(upd_t u);
			res_t w;
			logic clamped;
			int   lead, dwell, adv, cyl, tdc_deg, tdc_x10, spark, dws;
			clamped = 1'b0;
			if (u.op == OP_APPLY) begin
				if (u.pulse_request > 32'(PULSE_LIMIT)) begin
					held_pulse = 16'(PULSE_LIMIT);
					clamped = 1'b1;
					clamp_total++;
				end else begin
					held_pulse = u.pulse_request[15:0];
				end
				held_dead  = u.dead_time;
				held_soi   = u.soi_offset;
				held_adv   = u.spark_advance;
				held_dwell = u.dwell_angle_in;
			end
			lead  = int'(held_soi) % TURN_X10;
			dwell = int'(held_dwell) % TURN_X10;
			adv   = held_adv;
			for (int s = 0; s < NUM_SLOTS; s++) begin
				cyl     = int'(firing_slots[2*s +: 2]);
				tdc_deg = int'(tdc_deg_reg[cyl]) % TURN_DEG;
				tdc_x10 = tdc_deg * 10;
				spark   = (tdc_x10 - adv) % TURN_X10;
				if (spark < 0) spark += TURN_X10;
				dws = (spark + TURN_X10 - dwell) % TURN_X10;
				w.slot              = 2'(s);
				w.cylinder          = 2'(cyl);
				w.pulse_ticks       = held_pulse;
				w.dead_time_out     = held_dead;
				w.soi_angle         = 13'((tdc_x10 + TURN_X10 - lead) % TURN_X10);
				w.spark_angle       = 13'(spark);
				w.dwell_start_angle = 13'(dws);
				w.inj_trigger_pos   = wheel_code(step_back(tdc_deg, INJ_BACK));
				w.coil_set_pos      = wheel_code(step_back(dws / 10, IGN_BACK));
				w.coil_clear_pos    = wheel_code(step_back(spark / 10, IGN_BACK));
				w.was_clamped       = clamped;
				w.last              = (s == NUM_SLOTS - 1);
				expected_slots.push_back(w);
			end
		endfunction

		function void cmp(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
				failures++;
			end
		endfunction

		function void check_slot(res_t got);
			res_t want;
			if (expected_slots.size() == 0) begin
				$display("%0t: slot word with nothing pending, actual %h", $time, got);
				failures++;
				return;
			end
			want = expected_slots.pop_front();
			cmp("slot", want.slot, got.slot);
			cmp("cylinder", want.cylinder, got.cylinder);
			cmp("pulse_ticks", want.pulse_ticks, got.pulse_ticks);
			cmp("dead_time_out", want.dead_time_out, got.dead_time_out);
			cmp("soi_angle", want.soi_angle, got.soi_angle);
			cmp("spark_angle", want.spark_angle, got.spark_angle);
			cmp("dwell_start_angle", want.dwell_start_angle, got.dwell_start_angle);
			cmp("inj_trigger_pos", want.inj_trigger_pos, got.inj_trigger_pos);
			cmp("coil_set_pos", want.coil_set_pos, got.coil_set_pos);
			cmp("coil_clear_pos", want.coil_clear_pos, got.coil_clear_pos);
			cmp("was_clamped", want.was_clamped, got.was_clamped);
			cmp("last", want.last, got.last);
		endfunction

		function int pending();
			return expected_slots.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	int src_idle_pct  = 19;
	int sink_idle_pct = 19;
	int hold_cycles   = 0;

	slot_schedule_board board;

	ecas_upd_if upd_ch ();
	ecas_res_if res_ch ();

	engine_cycle_angle_scheduler_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (upd_ch),
		.res      (res_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (upd_ch.valid && upd_ch.ready) board.note_update(upd_ch.data);
			if (res_ch.valid && res_ch.ready) board.check_slot(res_ch.data);
		end
	end

	// result side: random back-pressure, or a long hold when requested
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				res_ch.ready <= 1'b0;
				hold_cycles--;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	task automatic send_update(input upd_t u);
		while ($urandom_range(99) < src_idle_pct) begin
			upd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		upd_ch.valid <= 1'b1;
		upd_ch.data  <= u;
		do @(posedge clk); while (!upd_ch.ready);
	endtask

	task automatic send_fields(input upd_op_t op, input logic [31:0] pw, input logic [15:0] dead,
			input logic [12:0] lead, input logic [15:0] adv, input logic [12:0] dwell);
		upd_t u;
		u.op             = op;
		u.pulse_request  = pw;
		u.dead_time      = dead;
		u.soi_offset     = lead;
		u.spark_advance  = adv;
		u.dwell_angle_in = dwell;
		send_update(u);
	endtask

	function automatic upd_t random_update();
		upd_t u;
		u.op = ($urandom_range(99) < 25) ? OP_REPLAY : OP_APPLY;
		case ($urandom_range(3))
			0: u.pulse_request = $urandom_range(PULSE_LIMIT);
			1: u.pulse_request = PULSE_LIMIT - 10 + $urandom_range(20);
			default: u.pulse_request = $urandom();
		endcase
		u.dead_time      = 16'($urandom());
		u.soi_offset     = ($urandom_range(9) == 0) ? 13'($urandom()) : 13'($urandom_range(7199));
		u.spark_advance  = ($urandom_range(1) == 0) ? 16'($urandom())
			: 16'($urandom_range(1200) - 600);
		u.dwell_angle_in = ($urandom_range(9) == 0) ? 13'($urandom()) : 13'($urandom_range(7199));
		return u;
	endfunction

	// hold the update channel quiet until every pending slot word is back
	task automatic drain();
		upd_ch.valid <= 1'b0;
		// let the monitor log a word accepted on this edge first
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
	endtask

	task automatic write_config(input logic [7:0] slots, input tdc_arr_t tdc);
		logic [9:0] v;
		for (int i = 0; i < 5; i++) begin
			if (i == 0) v = {2'b00, slots};
			else v = tdc[i-1];
			wr_en    <= 1'b1;
			wr_index <= reg_idx_t'(i);
			wr_data  <= v;
			@(posedge clk);
			board.set_reg(reg_idx_t'(i), v);
		end
		wr_en <= 1'b0;
	endtask

	initial begin
		int         guard;
		tdc_arr_t   tdc;
		logic [7:0] slots;
		board          = new();
		arst_n         = 1'b0;
		wr_en          = 1'b0;
		wr_index       = REG_FIRING_SLOTS;
		wr_data        = '0;
		upd_ch.valid   = 1'b0;
		upd_ch.data    = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: replay of the reset held values, field extremes, clamping
		send_fields(OP_REPLAY, 32'h0, 16'h0, 13'h0, 16'h0, 13'h0);
		send_fields(OP_APPLY, 32'd0, 16'd0, 13'd0, 16'd0, 13'd0);
		send_fields(OP_APPLY, 32'd65000, 16'hFFFF, 13'd7199, 16'h7FFF, 13'd7199);
		send_fields(OP_APPLY, 32'd65001, 16'd1, 13'h1FFF, 16'h8000, 13'h1FFF);
		send_fields(OP_REPLAY, 32'hFFFF_FFFF, 16'hFFFF, 13'h1FFF, 16'hFFFF, 13'h1FFF);
		send_fields(OP_APPLY, 32'hFFFF_FFFF, 16'd500, 13'd7200, 16'hFFFF, 13'd7200);
		send_fields(OP_APPLY, 32'd64999, 16'd250, 13'd3600, 16'd7200, 13'd1);
		send_fields(OP_APPLY, 32'd1, 16'd0, 13'd1, 16'(-7200), 13'd3600);
		send_fields(OP_APPLY, 32'h8000_0000, 16'd1234, 13'd840, 16'(-1), 13'd400);
		send_fields(OP_REPLAY, 32'd5, 16'd0, 13'd0, 16'd0, 13'd0);
		drain();

		// all slots on cylinder 0 at zero TDC
		write_config(8'h00, {10'd0, 10'd0, 10'd0, 10'd0});
		send_fields(OP_APPLY, 32'd2000, 16'd50, 13'd0, 16'd0, 13'd0);
		send_fields(OP_APPLY, 32'd2000, 16'd50, 13'd7199, 16'd1, 13'd7199);
		send_fields(OP_REPLAY, 32'd0, 16'd0, 13'd0, 16'd0, 13'd0);
		drain();

		// all slots on cylinder 3, offsets above 719 wrap
		write_config(8'hFF, {10'h3FF, 10'd720, 10'd1000, 10'd721});
		send_fields(OP_APPLY, 32'd70000, 16'd80, 13'd100, 16'd300, 13'd200);
		send_fields(OP_APPLY, 32'd3000, 16'd90, 13'd8000, 16'h8001, 13'd8191);
		drain();

		// natural order, offsets on the wheel boundaries
		write_config(8'b11_10_01_00, {10'd719, 10'd360, 10'd359, 10'd84});
		send_fields(OP_APPLY, 32'd4000, 16'd70, 13'd840, 16'd240, 13'd240);
		send_fields(OP_APPLY, 32'd4000, 16'd70, 13'd7190, 16'h7FFF, 13'd10);
		send_fields(OP_APPLY, 32'd65000, 16'd70, 13'd5, 16'(-32767), 13'd7000);
		send_fields(OP_REPLAY, 32'hFFFF_FFFF, 16'd0, 13'd0, 16'd0, 13'd0);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			slots = 8'($urandom_range(255));
			for (int c = 0; c < 4; c++)
				tdc[c] = ($urandom_range(3) == 0) ? 10'($urandom_range(1023, 720))
					: 10'($urandom_range(719));
			write_config(slots, tdc);
			src_idle_pct  = (ph == 2 || ph == 5) ? 0 : 19;
			sink_idle_pct = (ph == 2) ? 0 : 19;
			// hold the result side so the core backs up onto the update channel
			if (ph == 5) hold_cycles = 400;
			for (int n = 0; n < PHASE_ITEMS; n++) send_update(random_update());
			drain();
		end

		guard = 0;
		while (board.pending() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
		if (board.pending() != 0) begin
			$display("%0t: %0d slot words never arrived", $time, board.pending());
			board.failures++;
		end
		if (board.failures == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("%0t: timeout", $time);
		$display("status: fail");
		$finish;
	end

endmodule
